// ===== hw/rtl/shrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shrs_pkg
// Shared constants and types of the point history ring stack.
// ----------------------------------------------------------------------------
package shrs_pkg;

   localparam int RING_DEPTH = 128;
   localparam int COORD_BITS = 24;

   localparam int IDX_BITS   = $clog2(RING_DEPTH);
   localparam int POINT_BITS = 3 * COORD_BITS;
   localparam int DIST_BITS  = 50;
   localparam int SQ_BITS    = 2 * COORD_BITS + 2;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int CMP_BITS   = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

   localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(167772);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_BITS-1:0]          index_type;
   typedef logic [DIST_BITS-1:0]         dist_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic square_en;
      logic push_commit;
      logic pop_commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage : shrs_pkg
`default_nettype wire

// ===== hw/rtl/spot_history_ring_stack_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spot_history_ring_stack_core
// Bounded LIFO history of 3D points in a ring, with a minimum-spacing filter
// on pushes and overwrite of the oldest entry when full.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_stall   req_opcode, req_in_x, req_in_y, req_in_z
//  rsp      rsp_valid/rsp_stall   rsp_out_x/y/z, rsp_accepted, rsp_valid_res
//  csr      csr_write_enable      csr_write_data (min_dist_sq)
//
// A push steps through head read from the point RAM, the square stage, and
// compare and commit; a pop steps through head read and commit.
// One transaction is in flight at a time; req_stall is high while it is.
// A result waits in the output register; commit waits while a result is held there and rsp is stalled.
// Synchronous reset clears indices, the empty flag and the output valid.
// The point RAM is not cleared; only written entries are ever returned.
// ----------------------------------------------------------------------------
module spot_history_ring_stack_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_opcode,
   input  wire shrs_pkg::coord_type  req_in_x,
   input  wire shrs_pkg::coord_type  req_in_y,
   input  wire shrs_pkg::coord_type  req_in_z,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output shrs_pkg::coord_type       rsp_out_x,
   output shrs_pkg::coord_type       rsp_out_y,
   output shrs_pkg::coord_type       rsp_out_z,
   output logic                      rsp_accepted,
   output logic                      rsp_valid_res,
   input  wire logic                 csr_write_enable,
   input  wire shrs_pkg::dist_type   csr_write_data
);
   import shrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   shrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   shrs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_in_x         (req_in_x),
      .req_in_y         (req_in_y),
      .req_in_z         (req_in_z),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_accepted     (rsp_accepted),
      .rsp_valid_res    (rsp_valid_res)
   );

endmodule : spot_history_ring_stack_core
`default_nettype wire

// ===== hw/rtl/shrs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module shrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : shrs_ram
`default_nettype wire

// ===== hw/rtl/shrs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shrs_ctrl
// Sequencer: accepts one transaction, steps a push through read, square and
// commit (a pop skips square), and waits at commit while a held result is stalled.
// ----------------------------------------------------------------------------
module shrs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_opcode,
   output logic                      req_stall,
   input  wire shrs_pkg::status_type status,
   output shrs_pkg::cmd_type         cmd
);
   import shrs_pkg::*;

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_PUSH_SQ  = 2'd1;
   localparam logic [1:0] S_PUSH_CMT = 2'd2;
   localparam logic [1:0] S_POP_CMT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_opcode == OP_POP) ? S_POP_CMT : S_PUSH_SQ;
            end
         end
         S_PUSH_SQ: begin
            cmd.square_en = 1'b1;
            state_in      = S_PUSH_CMT;
         end
         S_PUSH_CMT: begin
            if (!status.out_busy) begin
               cmd.push_commit = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_POP_CMT: begin
            if (!status.out_busy) begin
               cmd.pop_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   // a push always enters the square stage in the cycle after it is accepted
   a_push_squares: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_opcode == OP_PUSH) |=> cmd.square_en)
      else $error("push did not enter square stage");
`endif

endmodule : shrs_ctrl
`default_nettype wire

// ===== hw/rtl/shrs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shrs_dp
// Datapath: point RAM, head/tail indices, distance squares, threshold compare
// and the result register.
// ----------------------------------------------------------------------------
module shrs_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire shrs_pkg::cmd_type    cmd,
   output shrs_pkg::status_type      status,
   input  wire shrs_pkg::coord_type  req_in_x,
   input  wire shrs_pkg::coord_type  req_in_y,
   input  wire shrs_pkg::coord_type  req_in_z,
   input  wire logic                 csr_write_enable,
   input  wire shrs_pkg::dist_type   csr_write_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output shrs_pkg::coord_type       rsp_out_x,
   output shrs_pkg::coord_type       rsp_out_y,
   output shrs_pkg::coord_type       rsp_out_z,
   output logic                      rsp_accepted,
   output logic                      rsp_valid_res
);
   import shrs_pkg::*;

   localparam index_type LAST_IDX = IDX_BITS'(RING_DEPTH - 1);

   dist_type  min_dist_sq_ff;
   index_type head_ff, head_in;
   index_type tail_ff, tail_in;
   logic      not_empty_ff, not_empty_in;

   coord_type x_ff, y_ff, z_ff;

   logic [POINT_BITS-1:0] rd_data;
   logic [POINT_BITS-1:0] wr_data;
   logic                  wr_en;
   index_type             wr_addr;
   coord_type             rd_x, rd_y, rd_z;

   logic [COORD_BITS:0]     dx, dy, dz;
   logic [COORD_BITS-1:0]   mag_x, mag_y, mag_z;
   logic [2*COORD_BITS-1:0] sqr_x, sqr_y, sqr_z;
   logic [SQ_BITS-1:0]      sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SUM_BITS-1:0]     dist_sum;
   logic                    far_enough;

   index_type head_next, head_prev, tail_next;

   logic      rsp_valid_ff, rsp_valid_in;
   coord_type rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic      rsp_acc_ff, rsp_vld_ff;

   // point memory, read at the head when a transaction is taken
   shrs_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[COORD_BITS-1:0];
   assign rd_y = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rd_z = rd_data[3*COORD_BITS-1:2*COORD_BITS];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff <= req_in_x;
         y_ff <= req_in_y;
         z_ff <= req_in_z;
      end
   end

   // exact per-axis differences; a magnitude never exceeds 2^COORD_BITS-1
   always_comb begin
      dx    = {rd_x[COORD_BITS-1], rd_x} - {x_ff[COORD_BITS-1], x_ff};
      dy    = {rd_y[COORD_BITS-1], rd_y} - {y_ff[COORD_BITS-1], y_ff};
      dz    = {rd_z[COORD_BITS-1], rd_z} - {z_ff[COORD_BITS-1], z_ff};
      mag_x = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      mag_y = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      mag_z = dz[COORD_BITS] ? COORD_BITS'(-dz) : dz[COORD_BITS-1:0];
      sqr_x = mag_x * mag_x;
      sqr_y = mag_y * mag_y;
      sqr_z = mag_z * mag_z;
   end

   always_ff @(posedge clock) begin
      if (cmd.square_en) begin
         sq_x_ff <= SQ_BITS'(sqr_x);
         sq_y_ff <= SQ_BITS'(sqr_y);
         sq_z_ff <= SQ_BITS'(sqr_z);
      end
   end

   // the sum never wraps, so no saturation is needed for the compare
   assign dist_sum   = SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff) + SUM_BITS'(sq_z_ff);
   assign far_enough = CMP_BITS'(dist_sum) >= CMP_BITS'(min_dist_sq_ff);

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   assign status.out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      not_empty_in = not_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = head_next;
      wr_data      = {z_ff, y_ff, x_ff};
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.push_commit) begin
         rsp_valid_in = 1'b1;
         if (!not_empty_ff) begin
            head_in      = '0;
            tail_in      = '0;
            not_empty_in = 1'b1;
            wr_en        = 1'b1;
            wr_addr      = '0;
         end else if (far_enough) begin
            head_in = head_next;
            wr_en   = 1'b1;
            // full ring: drop the oldest entry
            if (head_next == tail_ff) begin
               tail_in = tail_next;
            end
         end
      end
      if (cmd.pop_commit) begin
         rsp_valid_in = 1'b1;
         if (not_empty_ff && head_ff != tail_ff) begin
            head_in = head_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_sq_ff <= DIST_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         not_empty_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            min_dist_sq_ff <= csr_write_data;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         not_empty_ff <= not_empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_commit) begin
         rsp_x_ff   <= '0;
         rsp_y_ff   <= '0;
         rsp_z_ff   <= '0;
         rsp_acc_ff <= !not_empty_ff || far_enough;
         rsp_vld_ff <= 1'b0;
      end else if (cmd.pop_commit) begin
         rsp_x_ff   <= not_empty_ff ? rd_x : '0;
         rsp_y_ff   <= not_empty_ff ? rd_y : '0;
         rsp_z_ff   <= not_empty_ff ? rd_z : '0;
         rsp_acc_ff <= 1'b0;
         rsp_vld_ff <= not_empty_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_accepted  = rsp_acc_ff;
   assign rsp_valid_res = rsp_vld_ff;

`ifndef SYNTHESIS
   // once a point is stored the history never becomes empty again
   a_never_empties: assert property (@(posedge clock) disable iff (reset)
      not_empty_ff |=> not_empty_ff)
      else $error("history went empty");

   // a pop at the last remaining entry keeps the head in place
   a_pop_last_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_commit && not_empty_ff && head_ff == tail_ff) |=>
      (head_ff == $past(head_ff)))
      else $error("head moved past the oldest entry");

   // a commit never overwrites a result that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_commit || cmd.pop_commit) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule : shrs_dp
`default_nettype wire
